// ----- rtl/tqg_pkg.sv -----
// Package for the two-qubit gate state update block.
// Holds the payload structs, operation and register codes, FSM states and datapath widths.
// No dependencies.
`default_nettype none
package tqg_pkg;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 68;
  localparam int MAT_DEPTH = 16;
  localparam int MAT_AW    = 4;

  typedef enum logic [1:0] {
    MODE_WR_AMP = 2'd0,
    MODE_WR_MAT = 2'd1,
    MODE_APPLY  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_QUBIT_COUNT   = 2'd0,
    CFG_HIGH_POSITION = 2'd1,
    CFG_LOW_POSITION  = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_AP_RD,
    ST_AP_MAC,
    ST_AP_DRAIN
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic [9:0]         index;
    logic signed [31:0] real_in;
    logic signed [31:0] imag_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] real_out;
    logic signed [31:0] imag_out;
    logic               saturated;
    logic               done_res;
  } out_item_t;

  // Control tag that travels with one matrix term through the MAC pipeline.
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [1:0] row;
  } mac_ctl_t;

  typedef struct packed {
    logic                     valid;
    logic [1:0]               row;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     sat;
    logic                     busy;
  } mac_res_t;

  localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] RES_MIN = ACC_W'(-64'sd2147483648);

endpackage
`default_nettype wire

// ----- rtl/tqg_mac.sv -----
// Complex multiply-accumulate pipeline: product, accumulate, round and saturate stages.
// Depends on tqg_pkg.
`default_nettype none
module tqg_mac #(
  parameter int FRACTION_BITS = 30
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tqg_pkg::mac_ctl_t                 ctl_i,
  input  logic signed [tqg_pkg::DATA_W-1:0] mr_i,
  input  logic signed [tqg_pkg::DATA_W-1:0] mi_i,
  input  logic signed [tqg_pkg::DATA_W-1:0] vr_i,
  input  logic signed [tqg_pkg::DATA_W-1:0] vi_i,
  output tqg_pkg::mac_res_t                 res_o
);
  import tqg_pkg::*;

  mac_ctl_t                   p_ctl_q;
  logic signed [2*DATA_W-1:0] prr_q, pii_q, pri_q, pir_q;
  logic signed [ACC_W-1:0]    acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  logic                       a_fin_q;
  logic [1:0]                 a_row_q;
  logic                       r_v_q;
  logic [1:0]                 r_row_q;
  logic signed [DATA_W-1:0]   r_re_q, r_im_q;
  logic                       r_sat_q;
  logic signed [DATA_W-1:0]   fin_re, fin_im;
  logic                       sat_re, sat_im;

  function automatic logic signed [DATA_W:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] sh;
    rnd = a + (ACC_W'(1) <<< (FRACTION_BITS - 1));
    sh  = rnd >>> FRACTION_BITS;
    if (sh > RES_MAX) begin
      round_sat = {1'b1, RES_MAX[DATA_W-1:0]};
    end else if (sh < RES_MIN) begin
      round_sat = {1'b1, RES_MIN[DATA_W-1:0]};
    end else begin
      round_sat = {1'b0, sh[DATA_W-1:0]};
    end
  endfunction

  always_comb begin
    acc_re_d = (p_ctl_q.first ? '0 : acc_re_q) + ACC_W'(prr_q) - ACC_W'(pii_q);
    acc_im_d = (p_ctl_q.first ? '0 : acc_im_q) + ACC_W'(pri_q) + ACC_W'(pir_q);
    {sat_re, fin_re} = round_sat(acc_re_q);
    {sat_im, fin_im} = round_sat(acc_im_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_ctl_q <= '0;
      a_fin_q <= 1'b0;
      r_v_q   <= 1'b0;
    end else begin
      p_ctl_q <= ctl_i;
      a_fin_q <= p_ctl_q.valid & p_ctl_q.last;
      r_v_q   <= a_fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prr_q <= mr_i * vr_i;
    pii_q <= mi_i * vi_i;
    pri_q <= mr_i * vi_i;
    pir_q <= mi_i * vr_i;
    if (p_ctl_q.valid) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
      a_row_q  <= p_ctl_q.row;
    end
    r_re_q  <= fin_re;
    r_im_q  <= fin_im;
    r_sat_q <= sat_re | sat_im;
    r_row_q <= a_row_q;
  end

  assign res_o.valid = r_v_q;
  assign res_o.row   = r_row_q;
  assign res_o.re    = r_re_q;
  assign res_o.im    = r_im_q;
  assign res_o.sat   = r_sat_q;
  assign res_o.busy  = p_ctl_q.valid | a_fin_q | r_v_q;

endmodule
`default_nettype wire

// ----- rtl/two_qubit_gate_state_update.sv -----
// Top level of the two-qubit gate state update block.
// Holds the amplitude and matrix memories and the sequencer; uses tqg_pkg and tqg_mac.
`default_nettype none
// A command is taken when start_i is high and busy_o is low. Every command gives exactly
// one result, shown on result_o for a single cycle with res_valid_o high; the receiver
// cannot stall it, so capture it when it shows. Amplitude write and matrix write register
// their result from the execute state; amplitude read passes the registered memory read
// first. Apply walks the 2^(q-2) groups of four amplitudes (q is the clamped qubit count);
// for each group it reads four amplitudes through the single amplitude read port, feeds
// sixteen matrix terms through the one complex multiply-accumulate pipeline, then drains
// that pipeline and writes the last row back. An apply with equal or out-of-range gate
// positions returns at once with done_res low. Memories need no clearing after reset.
// Configuration writes are always ready and are meant for idle periods only.
module two_qubit_gate_state_update #(
  parameter int MAX_QUBITS    = 10,
  parameter int FRACTION_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  tqg_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output tqg_pkg::out_item_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i
);
  import tqg_pkg::*;

  localparam int AW    = MAX_QUBITS;
  localparam int DEPTH = 1 << AW;

  // Amplitude and gate memories: {real, imag}, registered read.
  logic [2*DATA_W-1:0] amp_mem [DEPTH];
  logic [2*DATA_W-1:0] mat_mem [MAT_DEPTH];
  logic [2*DATA_W-1:0] amp_rdata_q, mat_rdata_q;

  logic                amp_we, mat_we;
  logic [AW-1:0]       amp_waddr, amp_raddr;
  logic [2*DATA_W-1:0] amp_wdata, mat_wdata;
  logic [MAT_AW-1:0]   mat_waddr, mat_raddr;

  state_e state_q, state_d;

  logic [3:0] qc_q, hp_q, lp_q;

  in_item_t  item_q;
  logic [AW-1:0] g_q;
  logic [1:0]    k_q;
  logic [3:0]    rc_q;
  logic          rd_v_q;
  logic [1:0]    rd_k_q;
  logic          s1_v_q;
  logic [3:0]    s1_rc_q;
  logic signed [DATA_W-1:0] old_re_q [4];
  logic signed [DATA_W-1:0] old_im_q [4];
  logic          sat_q;
  logic          res_valid_q;
  out_item_t     res_q, res_d;
  logic          res_fire;

  logic [3:0]    q_eff, pmin, pmax;
  logic          bad_pos, g_last, pipe_idle;
  logic [AW-1:0] ins0, base, dl, dh;
  logic [AW-1:0] idx [4];

  mac_ctl_t mac_ctl;
  mac_res_t mac_res;

  // Clamp qubit count and check gate positions.
  always_comb begin
    if (qc_q < 4'd2) begin
      q_eff = 4'd2;
    end else if (int'(qc_q) > MAX_QUBITS) begin
      q_eff = 4'(MAX_QUBITS);
    end else begin
      q_eff = qc_q;
    end
    bad_pos = (hp_q == lp_q) || (hp_q >= q_eff) || (lp_q >= q_eff);
  end

  // Spread the group counter around the two gate bits to form the group base.
  always_comb begin
    pmin = (hp_q < lp_q) ? hp_q : lp_q;
    pmax = (hp_q < lp_q) ? lp_q : hp_q;
    ins0 = ((g_q >> pmin) << (pmin + 4'd1)) | (g_q & ((AW'(1) << pmin) - AW'(1)));
    base = ((ins0 >> pmax) << (pmax + 4'd1)) | (ins0 & ((AW'(1) << pmax) - AW'(1)));
    dl   = AW'(1) << lp_q;
    dh   = AW'(1) << hp_q;
    idx[0] = base;
    idx[1] = base | dl;
    idx[2] = base | dh;
    idx[3] = base | dh | dl;
    g_last = (g_q == ((AW'(1) << (q_eff - 4'd2)) - AW'(1)));
  end

  assign pipe_idle = !s1_v_q && !mac_res.busy;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (item_q.mode)
          MODE_READ:  state_d = ST_RDATA;
          MODE_APPLY: state_d = bad_pos ? ST_IDLE : ST_AP_RD;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_RDATA:  state_d = ST_IDLE;
      ST_AP_RD: begin
        if (k_q == 2'd3) state_d = ST_AP_MAC;
      end
      ST_AP_MAC: begin
        if (rc_q == 4'd15) state_d = ST_AP_DRAIN;
      end
      ST_AP_DRAIN: begin
        if (pipe_idle) state_d = g_last ? ST_IDLE : ST_AP_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory strobes and result.
  always_comb begin
    amp_we    = 1'b0;
    amp_waddr = AW'(item_q.index);
    amp_wdata = {item_q.real_in, item_q.imag_in};
    amp_raddr = AW'(item_q.index);
    mat_we    = 1'b0;
    mat_waddr = item_q.index[MAT_AW-1:0];
    mat_wdata = {item_q.real_in, item_q.imag_in};
    mat_raddr = rc_q;
    res_fire  = 1'b0;
    res_d     = '0;
    case (state_q)
      ST_EXEC: begin
        case (item_q.mode)
          MODE_WR_AMP: begin
            amp_we         = 1'b1;
            res_fire       = 1'b1;
            res_d.done_res = 1'b1;
          end
          MODE_WR_MAT: begin
            mat_we         = (item_q.index < 10'(MAT_DEPTH));
            res_fire       = 1'b1;
            res_d.done_res = mat_we;
          end
          MODE_APPLY: begin
            res_fire = bad_pos;
          end
          default: begin
          end
        endcase
      end
      ST_RDATA: begin
        res_fire       = 1'b1;
        res_d.real_out = amp_rdata_q[2*DATA_W-1:DATA_W];
        res_d.imag_out = amp_rdata_q[DATA_W-1:0];
        res_d.done_res = 1'b1;
      end
      ST_AP_RD: begin
        amp_raddr = idx[k_q];
      end
      ST_AP_DRAIN: begin
        if (pipe_idle && g_last) begin
          res_fire        = 1'b1;
          res_d.saturated = sat_q;
          res_d.done_res  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // Write back each new amplitude as it leaves the pipeline.
    if (mac_res.valid) begin
      amp_we    = 1'b1;
      amp_waddr = idx[mac_res.row];
      amp_wdata = {mac_res.re, mac_res.im};
    end
  end

  always_ff @(posedge clk_i) begin
    if (amp_we) amp_mem[amp_waddr] <= amp_wdata;
    amp_rdata_q <= amp_mem[amp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) mat_mem[mat_waddr] <= mat_wdata;
    mat_rdata_q <= mat_mem[mat_raddr];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      qc_q        <= 4'd10;
      hp_q        <= 4'd1;
      lp_q        <= 4'd0;
      g_q         <= '0;
      k_q         <= '0;
      rc_q        <= '0;
      rd_v_q      <= 1'b0;
      s1_v_q      <= 1'b0;
      sat_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_fire;
      rd_v_q      <= (state_q == ST_AP_RD);
      s1_v_q      <= (state_q == ST_AP_MAC);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_QUBIT_COUNT:   qc_q <= cfg_data_i;
          CFG_HIGH_POSITION: hp_q <= cfg_data_i;
          CFG_LOW_POSITION:  lp_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      case (state_q)
        ST_EXEC: begin
          g_q   <= '0;
          k_q   <= '0;
          sat_q <= 1'b0;
        end
        ST_AP_RD: begin
          k_q  <= k_q + 2'd1;
          rc_q <= '0;
        end
        ST_AP_MAC: rc_q <= rc_q + 4'd1;
        ST_AP_DRAIN: begin
          if (pipe_idle) g_q <= g_q + AW'(1);
        end
        default: begin
        end
      endcase
      if (mac_res.valid) sat_q <= sat_q | mac_res.sat;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == ST_IDLE)) item_q <= item_i;
    rd_k_q  <= k_q;
    s1_rc_q <= rc_q;
    if (rd_v_q) begin
      old_re_q[rd_k_q] <= amp_rdata_q[2*DATA_W-1:DATA_W];
      old_im_q[rd_k_q] <= amp_rdata_q[DATA_W-1:0];
    end
    if (res_fire) res_q <= res_d;
  end

  assign mac_ctl.valid = s1_v_q;
  assign mac_ctl.first = (s1_rc_q[1:0] == 2'd0);
  assign mac_ctl.last  = (s1_rc_q[1:0] == 2'd3);
  assign mac_ctl.row   = s1_rc_q[3:2];

  tqg_mac #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mac_ctl),
    .mr_i  (mat_rdata_q[2*DATA_W-1:DATA_W]),
    .mi_i  (mat_rdata_q[DATA_W-1:0]),
    .vr_i  (old_re_q[s1_rc_q[1:0]]),
    .vi_i  (old_im_q[s1_rc_q[1:0]]),
    .res_o (mac_res)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign result_o    = res_q;
  assign cfg_ready_o = 1'b1;

endmodule
`default_nettype wire

// ----- rtl/tqg_checker.sv -----
// Port-level checker for the two-qubit gate state update block, with its bind.
// Depends on tqg_pkg and two_qubit_gate_state_update.
`default_nettype none
module tqg_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic               res_valid_o,
  input wire tqg_pkg::out_item_t result_o
);
  import tqg_pkg::*;

  // Each result strobe lasts exactly one cycle.
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobe held two cycles");

  // A transfer makes the block busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("busy not raised after transfer");

  // The block leaves busy only with a result.
  a_result_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_valid_o) else $error("busy dropped without result");

  // Saturation is reported only on a completed apply.
  a_sat_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && result_o.saturated) |-> result_o.done_res)
    else $error("saturation flagged on failed operation");

  // Nonzero read data comes only with a completed operation.
  a_data_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (result_o.real_out != '0 || result_o.imag_out != '0))
      |-> result_o.done_res) else $error("data on failed operation");

endmodule

bind two_qubit_gate_state_update tqg_checker u_tqg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .res_valid_o(res_valid_o),
  .result_o   (result_o)
);
`default_nettype wire

// ----- dv/two_qubit_gate_state_update_test.sv -----
// Self-checking testbench for the two-qubit gate state update block.
// Drives commands and register writes and checks each result against a gate predictor.
// Depends on tqg_pkg and two_qubit_gate_state_update.
`timescale 1ns / 1ps
module two_qubit_gate_state_update_test;
  import tqg_pkg::*;

  localparam int VEC_SIZE   = 1024;
  localparam int STALL_MAX  = 30000;
  localparam int MAX_REPORT = 10;
  localparam int NUM_PHASES = 14;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  logic      busy_o;
  in_item_t  item_i = '0;
  logic      res_valid_o;
  out_item_t result_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [1:0] cfg_index_i = CFG_QUBIT_COUNT;
  logic [3:0] cfg_data_i = '0;

  two_qubit_gate_state_update dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .res_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: its own copy of both memories and of the three registers.
  logic signed [31:0] amp_re [VEC_SIZE];
  logic signed [31:0] amp_im [VEC_SIZE];
  bit                 amp_set [VEC_SIZE];
  logic signed [31:0] mat_re [MAT_DEPTH];
  logic signed [31:0] mat_im [MAT_DEPTH];
  bit                 mat_set [MAT_DEPTH];
  logic [3:0]         qubits_reg = 4'd10;
  logic [3:0]         high_reg = 4'd1;
  logic [3:0]         low_reg = 4'd0;

  out_item_t pending_results[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        applies_done = 0;
  int        saturations = 0;
  int        bad_applies = 0;
  bit        quiet = 1'b0;

  function automatic int active_qubits();
    if (qubits_reg < 2) return 2;
    if (qubits_reg > 10) return 10;
    return int'(qubits_reg);
  endfunction

  // Round half up to 30 fraction bits, then clamp to the signed 32-bit range.
  function automatic logic signed [31:0] round_sat(input logic signed [71:0] acc,
                                                    inout bit sat);
    logic signed [71:0] r;
    r = (acc + 72'sd536870912) >>> 30;
    if (r > 72'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (r < -72'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

  // Multiply the gate into every group of four amplitudes; return 0 on bad positions.
  function automatic bit gate_apply(inout bit sat);
    int q;
    int dh;
    int dl;
    int idx[4];
    logic signed [31:0] ore[4];
    logic signed [31:0] oim[4];
    logic signed [71:0] acc_re;
    logic signed [71:0] acc_im;
    longint mr, mi, vr, vi;
    q = active_qubits();
    if (high_reg == low_reg || high_reg >= q || low_reg >= q) return 1'b0;
    dh = 1 << high_reg;
    dl = 1 << low_reg;
    for (int b = 0; b < (1 << q); b++) begin
      if ((b & dh) != 0 || (b & dl) != 0) continue;
      idx[0] = b; idx[1] = b + dl; idx[2] = b + dh; idx[3] = b + dh + dl;
      for (int c = 0; c < 4; c++) begin
        ore[c] = amp_re[idx[c]];
        oim[c] = amp_im[idx[c]];
      end
      for (int t = 0; t < 4; t++) begin
        acc_re = '0;
        acc_im = '0;
        for (int c = 0; c < 4; c++) begin
          mr = mat_re[t*4+c]; mi = mat_im[t*4+c];
          vr = ore[c];        vi = oim[c];
          acc_re = acc_re + (mr * vr) - (mi * vi);
          acc_im = acc_im + (mr * vi) + (mi * vr);
        end
        amp_re[idx[t]] = round_sat(acc_re, sat);
        amp_im[idx[t]] = round_sat(acc_im, sat);
      end
    end
    return 1'b1;
  endfunction

  // Advance the predictor by one command and return the result it must give.
  function automatic out_item_t gate_predict(input in_item_t it);
    out_item_t r;
    bit sat;
    r = '0;
    sat = 1'b0;
    case (it.mode)
      MODE_WR_AMP: begin
        amp_re[it.index] = it.real_in;
        amp_im[it.index] = it.imag_in;
        amp_set[it.index] = 1'b1;
        r.done_res = 1'b1;
      end
      MODE_WR_MAT: begin
        if (it.index < MAT_DEPTH) begin
          mat_re[it.index] = it.real_in;
          mat_im[it.index] = it.imag_in;
          mat_set[it.index] = 1'b1;
          r.done_res = 1'b1;
        end
      end
      MODE_APPLY: begin
        r.done_res = gate_apply(sat);
        r.saturated = sat;
        if (r.done_res) applies_done++; else bad_applies++;
        if (sat) saturations++;
      end
      default: begin
        r.real_out = amp_re[it.index];
        r.imag_out = amp_im[it.index];
        r.done_res = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Check every result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT) $display("unexpected result %p", result_o);
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (result_o.real_out !== want.real_out || result_o.imag_out !== want.imag_out ||
            result_o.saturated !== want.saturated || result_o.done_res !== want.done_res) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display({"mismatch: expected re=%h im=%h sat=%b done=%b,",
                      " got re=%h im=%h sat=%b done=%b"},
                     want.real_out, want.imag_out, want.saturated, want.done_res,
                     result_o.real_out, result_o.imag_out, result_o.saturated,
                     result_o.done_res);
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer of any kind.
  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_MAX) begin
      $display("timeout: no transfer for %0d cycles", STALL_MAX);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one command: maybe idle for a burst first, then hold start until the transfer.
  task automatic send_command(input in_item_t it, input bit typed, input out_item_t typed_res);
    int gap;
    out_item_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    predicted = gate_predict(it);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drain all results, then write the three registers back to back.
  task automatic write_registers(input logic [3:0] q, input logic [3:0] h, input logic [3:0] l);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1; cfg_index_i <= CFG_QUBIT_COUNT; cfg_data_i <= q;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_HIGH_POSITION; cfg_data_i <= h;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_LOW_POSITION; cfg_data_i <= l;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    qubits_reg = q;
    high_reg = h;
    low_reg = l;
  endtask

  function automatic logic signed [31:0] rand_part();
    if ($urandom_range(0, 3) == 0) return $signed($urandom);
    return $signed($urandom_range(0, 1 << 30)) - 32'sd536870912;
  endfunction

  function automatic int first_amp_hole(input int limit);
    for (int i = 0; i < limit; i++) if (!amp_set[i]) return i;
    return -1;
  endfunction

  function automatic int first_mat_hole();
    for (int i = 0; i < MAT_DEPTH; i++) if (!mat_set[i]) return i;
    return -1;
  endfunction

  // Draw one random command; never read or apply over an entry that was never written.
  function automatic in_item_t random_command();
    in_item_t it;
    int roll;
    int apply_pct;
    int hole;
    it.mode    = MODE_WR_AMP;
    it.index   = 10'($urandom);
    it.real_in = rand_part();
    it.imag_in = rand_part();
    apply_pct  = (active_qubits() <= 6) ? 15 : 3;
    roll       = $urandom_range(0, 99);
    if (roll < apply_pct) begin
      it.mode = MODE_APPLY;
      hole = first_mat_hole();
      if (hole >= 0) begin
        it.mode = MODE_WR_MAT;
        it.index = 10'(hole);
      end else begin
        hole = first_amp_hole(1 << active_qubits());
        if (hole >= 0) begin
          it.mode = MODE_WR_AMP;
          it.index = 10'(hole);
        end
      end
    end else if (roll < apply_pct + 15) begin
      it.mode = MODE_WR_MAT;
      if ($urandom_range(0, 4) != 0) it.index = 10'($urandom_range(0, MAT_DEPTH - 1));
    end else if (roll < apply_pct + 45) begin
      it.mode = MODE_READ;
      for (int k = 0; k < 8 && !amp_set[it.index]; k++) it.index = 10'($urandom);
      if (!amp_set[it.index]) it.index = '0;
    end else if ($urandom_range(0, 1) == 0) begin
      hole = first_amp_hole(VEC_SIZE);
      if (hole >= 0) it.index = 10'(hole);
    end
    return it;
  endfunction

  typedef struct {
    mode_e              mode;
    logic [9:0]         index;
    logic signed [31:0] re;
    logic signed [31:0] im;
    out_item_t          res;
  } directed_row_t;

  // Extremes of every field, read-back of each, and matrix writes past entry fifteen.
  directed_row_t directed_rows[] = '{
    '{MODE_WR_AMP, 10'd0,    32'sh7FFFFFFF, 32'sh80000000, '{32'sh0, 32'sh0, 1'b0, 1'b1}},
    '{MODE_READ,   10'd0,    32'sh0,        32'sh0,
      '{32'sh7FFFFFFF, 32'sh80000000, 1'b0, 1'b1}},
    '{MODE_WR_AMP, 10'd1023, 32'sh80000000, 32'sh7FFFFFFF, '{32'sh0, 32'sh0, 1'b0, 1'b1}},
    '{MODE_READ,   10'd1023, 32'shFFFFFFFF, 32'shFFFFFFFF,
      '{32'sh80000000, 32'sh7FFFFFFF, 1'b0, 1'b1}},
    '{MODE_WR_AMP, 10'd512,  32'sh55555555, 32'shAAAAAAAA, '{32'sh0, 32'sh0, 1'b0, 1'b1}},
    '{MODE_READ,   10'd512,  32'sh0,        32'sh0,
      '{32'sh55555555, 32'shAAAAAAAA, 1'b0, 1'b1}},
    '{MODE_WR_AMP, 10'd682,  32'shFFFFFFFF, 32'sh0,        '{32'sh0, 32'sh0, 1'b0, 1'b1}},
    '{MODE_READ,   10'd682,  32'sh0,        32'sh0,
      '{32'shFFFFFFFF, 32'sh0, 1'b0, 1'b1}},
    '{MODE_WR_MAT, 10'd0,    32'sh7FFFFFFF, 32'sh80000000, '{32'sh0, 32'sh0, 1'b0, 1'b1}},
    '{MODE_WR_MAT, 10'd15,   32'sh0,        32'shFFFFFFFF, '{32'sh0, 32'sh0, 1'b0, 1'b1}},
    '{MODE_WR_MAT, 10'd16,   32'sh1,        32'sh1,        '{32'sh0, 32'sh0, 1'b0, 1'b0}},
    '{MODE_WR_MAT, 10'd1023, 32'shFFFFFFFF, 32'shFFFFFFFF, '{32'sh0, 32'sh0, 1'b0, 1'b0}}
  };

  // Register settings per phase: clamped counts, equal and out-of-range positions,
  // and the largest vector with the positions at both ends.
  logic [3:0] phase_q [NUM_PHASES] = '{4'd2, 4'd2, 4'd3, 4'd0, 4'd4, 4'd5, 4'd3,
                                       4'd6, 4'd15, 4'd3, 4'd8, 4'd10, 4'd15, 4'd3};
  logic [3:0] phase_h [NUM_PHASES] = '{4'd1, 4'd0, 4'd2, 4'd1, 4'd3, 4'd2, 4'd7,
                                       4'd0, 4'd15, 4'd1, 4'd7, 4'd9, 4'd0, 4'd2};
  logic [3:0] phase_l [NUM_PHASES] = '{4'd0, 4'd1, 4'd0, 4'd0, 4'd2, 4'd2, 4'd0,
                                       4'd5, 4'd0, 4'd15, 4'd3, 4'd0, 4'd9, 4'd1};

  initial begin
    in_item_t it;
    out_item_t typed_res;
    int sent;
    sent = 0;
    typed_res = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run under the reset register values.
    foreach (directed_rows[i]) begin
      it.mode    = directed_rows[i].mode;
      it.index   = directed_rows[i].index;
      it.real_in = directed_rows[i].re;
      it.imag_in = directed_rows[i].im;
      send_command(it, 1'b1, directed_rows[i].res);
      sent++;
    end
    repeat (40) begin
      send_command(random_command(), 1'b0, typed_res);
      sent++;
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_registers(phase_q[p], phase_h[p], phase_l[p]);
      quiet = (p == NUM_PHASES - 1);
      repeat (50) begin
        send_command(random_command(), 1'b0, typed_res);
        sent++;
      end
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d commands, %0d results, %0d gate applies (%0d saturating)",
             sent, results_seen, applies_done, saturations);
    $display("plus %0d rejected applies over %0d register settings",
             bad_applies, NUM_PHASES + 1);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
